// ----- hw/rtl/bfdh_pkg.sv -----
// Shared constants, types and codes for the double-hash Bloom filter engine.
// Depends on nothing; every other file of the block imports it.

package bfdh_pkg;

   // Capacity of the byte store and derived address and index widths.
   localparam int FILTER_BYTES = 8192;
   localparam int ADDR_W       = $clog2(FILTER_BYTES);
   localparam int IDX_W        = ADDR_W + 3;      // bit index, always below the modulus
   localparam int MOD_W        = IDX_W + 1;       // modulus itself, up to 8 * FILTER_BYTES
   localparam int ACC_W        = IDX_W + 2;       // value fed to the modulo step, below 4 * m

   // Hash count limits.
   localparam int MAX_HASHES   = 32;
   localparam int CNT_W        = $clog2(MAX_HASHES + 1);

   // Register field widths fixed by the register map.
   localparam int HC_W         = 6;
   localparam int FS_W         = 14;
   localparam int CSR_ADDR_W   = 2;

   // Digest handling: two bits are consumed per reduction step.
   localparam int WORD_W       = 64;
   localparam int DIGEST_W     = 4 * WORD_W;
   localparam int SHIFT_W      = 2 * DIGEST_W;
   localparam int STEP_W       = $clog2(DIGEST_W / 2);

   localparam logic [HC_W-1:0] HASH_COUNT_RESET = HC_W'(10);
   localparam logic [FS_W-1:0] FILTER_SIZE_RESET = FS_W'(8192);

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_HASH_COUNT  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_SIZE = CSR_ADDR_W'(1);

   typedef enum logic {
      MODE_ADD   = 1'b0,
      MODE_CHECK = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_FIRST,
      ST_RED_SECOND,
      ST_READ,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   // Access request from the sequencer to the byte store.
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wr_data;
   } mem_req_type;

   // Finished membership answer handed to the response register.
   typedef struct packed {
      logic valid;
      logic member;
   } result_type;

endpackage

// ----- hw/rtl/bloom_filter_double_hash.sv -----
// Top level of the double-hash Bloom filter engine: registers, response slot, wiring.
// Depends on bfdh_pkg, bfdh_modstep, bfdh_store and bfdh_ctrl.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  mode, two 256-bit digests as 64-bit words
//   rsp_      out        rsp_valid / rsp_ready  is_member (check transactions only)
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// After reset the byte store is swept to zero, one byte per cycle;
// req_ready stays low during the sweep while register writes are taken as usual.
// A transaction passes through an accept state, the two digest reductions
// (two bits per cycle through the shared modulo step), a read and an update state
// per hash index for the read-modify-write of the single-port store, and a
// finishing state.
// A finished check waits in its finishing state only while the response register
// still holds an answer that has not been taken.

module bloom_filter_double_hash
   import bfdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [WORD_W-1:0]     req_first_digest_w3,
   input  logic [WORD_W-1:0]     req_first_digest_w2,
   input  logic [WORD_W-1:0]     req_first_digest_w1,
   input  logic [WORD_W-1:0]     req_first_digest_w0,
   input  logic [WORD_W-1:0]     req_second_digest_w3,
   input  logic [WORD_W-1:0]     req_second_digest_w2,
   input  logic [WORD_W-1:0]     req_second_digest_w1,
   input  logic [WORD_W-1:0]     req_second_digest_w0,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_is_member,

   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [FS_W-1:0]       csr_wdata
);

   // Configuration registers. Writes to unknown indexes are dropped.
   logic [HC_W-1:0] hash_count_ff, hash_count_in;
   logic [FS_W-1:0] filter_size_ff, filter_size_in;

   // Response slot. It lets the sequencer take a new transaction while an
   // answer is still waiting for the consumer.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_member_ff, rsp_member_in;
   logic rsp_busy;

   mem_req_type      mem_req;
   result_type       result;
   logic [7:0]       rd_data;
   logic             store_busy;
   logic [ACC_W-1:0] mod_val;
   logic [MOD_W-1:0] mod_m;
   logic [IDX_W-1:0] mod_rem;

   always_comb begin
      hash_count_in  = hash_count_ff;
      filter_size_in = filter_size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_HASH_COUNT: begin
               hash_count_in = csr_wdata[HC_W-1:0];
            end
            CSR_FILTER_SIZE: begin
               filter_size_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff  <= HASH_COUNT_RESET;
         filter_size_ff <= FILTER_SIZE_RESET;
      end else begin
         hash_count_ff  <= hash_count_in;
         filter_size_ff <= filter_size_in;
      end
   end

   // The slot is busy when it holds an answer that is not taken this cycle.
   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_busy || result.valid;
      rsp_member_in = result.valid ? result.member : rsp_member_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_member_ff <= rsp_member_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_member = rsp_member_ff;

   bfdh_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .first_w3        (req_first_digest_w3),
      .first_w2        (req_first_digest_w2),
      .first_w1        (req_first_digest_w1),
      .first_w0        (req_first_digest_w0),
      .second_w3       (req_second_digest_w3),
      .second_w2       (req_second_digest_w2),
      .second_w1       (req_second_digest_w1),
      .second_w0       (req_second_digest_w0),
      .cfg_hash_count  (hash_count_ff),
      .cfg_filter_size (filter_size_ff),
      .store_busy      (store_busy),
      .rd_data         (rd_data),
      .rsp_busy        (rsp_busy),
      .mod_rem         (mod_rem),
      .mod_val         (mod_val),
      .mod_m           (mod_m),
      .mem_req         (mem_req),
      .result          (result)
   );

   bfdh_modstep u_modstep (
      .val     (mod_val),
      .modulus (mod_m),
      .rem     (mod_rem)
   );

   bfdh_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   // A new answer must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !rsp_busy)
      else $error("response overwritten while still pending");

   // The sequencer must not touch the store during the clearing sweep.
   assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en || mem_req.rd_en) |-> !store_busy)
      else $error("store accessed during clearing sweep");

   // The sweep starts right after reset, so no transaction is taken then.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("transaction accepted before the store was cleared");

   // The store has one port: a read and a write never share a cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en))
      else $error("simultaneous store read and write");

endmodule

// ----- hw/rtl/bfdh_modstep.sv -----
// Shared modulo step: reduces a value below four times the modulus.
// Depends on bfdh_pkg for widths.

module bfdh_modstep
   import bfdh_pkg::*;
(
   input  logic [ACC_W-1:0] val,
   input  logic [MOD_W-1:0] modulus,
   output logic [IDX_W-1:0] rem
);

   logic [ACC_W-1:0] m1;
   logic [ACC_W-1:0] m2;
   logic [ACC_W-1:0] m3;
   logic [ACC_W-1:0] sub;

   // Pick the largest multiple of the modulus that does not exceed the value.
   always_comb begin
      m1 = ACC_W'(modulus);
      m2 = m1 << 1;
      m3 = m1 + m2;
      if (val >= m3) begin
         sub = m3;
      end else if (val >= m2) begin
         sub = m2;
      end else if (val >= m1) begin
         sub = m1;
      end else begin
         sub = '0;
      end
      rem = IDX_W'(val - sub);
   end

endmodule

// ----- hw/rtl/bfdh_store.sv -----
// Byte store of the filter with a clearing sweep after reset.
// Depends on bfdh_pkg for the store size and the request struct.

module bfdh_store
   import bfdh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data,
   output logic        busy
);

   logic [7:0]      mem [FILTER_BYTES];
   logic [7:0]      rd_data_ff;
   logic [ADDR_W:0] clr_cnt_ff;
   logic [ADDR_W:0] clr_cnt_in;

   assign busy = (clr_cnt_ff != (ADDR_W+1)'(FILTER_BYTES));

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (busy) begin
         clr_cnt_in = clr_cnt_ff + (ADDR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // One write port shared by the clearing sweep and the sequencer.
   always_ff @(posedge clock) begin
      if (busy) begin
         mem[clr_cnt_ff[ADDR_W-1:0]] <= '0;
      end else if (mem_req.wr_en) begin
         mem[mem_req.addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bfdh_ctrl.sv -----
// Sequencer: digest reduction, index generation and store updates or checks.
// Depends on bfdh_pkg; drives the shared modulo step and the byte store.

module bfdh_ctrl
   import bfdh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [WORD_W-1:0] first_w3,
   input  logic [WORD_W-1:0] first_w2,
   input  logic [WORD_W-1:0] first_w1,
   input  logic [WORD_W-1:0] first_w0,
   input  logic [WORD_W-1:0] second_w3,
   input  logic [WORD_W-1:0] second_w2,
   input  logic [WORD_W-1:0] second_w1,
   input  logic [WORD_W-1:0] second_w0,
   input  logic [HC_W-1:0]   cfg_hash_count,
   input  logic [FS_W-1:0]   cfg_filter_size,
   input  logic              store_busy,
   input  logic [7:0]        rd_data,
   input  logic              rsp_busy,
   input  logic [IDX_W-1:0]  mod_rem,
   output logic [ACC_W-1:0]  mod_val,
   output logic [MOD_W-1:0]  mod_m,
   output mem_req_type       mem_req,
   output result_type        result
);

   state_type          state_ff, state_in;
   mode_type           mode_ff, mode_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]   r_ff, r_in;
   logic [IDX_W-1:0]   h1_ff, h1_in;
   logic [IDX_W-1:0]   h2_ff, h2_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MOD_W-1:0]   m_ff, m_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               member_ff, member_in;

   logic               accept;
   logic               last_step;
   logic [CNT_W-1:0]   cnt_next;
   logic               bit_set;
   logic [FS_W-1:0]    bytes_eff;
   logic [HC_W-1:0]    hc_eff;

   assign accept    = req_valid && req_ready;
   assign last_step = (step_ff == STEP_W'(DIGEST_W / 2 - 1));
   assign cnt_next  = cnt_ff + CNT_W'(1);
   assign bit_set   = rd_data[idx_ff[2:0]];

   // Zero size counts as one byte; sizes past the store and hash counts past the maximum saturate.
   always_comb begin
      if (cfg_filter_size == '0) begin
         bytes_eff = FS_W'(1);
      end else if (cfg_filter_size > FS_W'(FILTER_BYTES)) begin
         bytes_eff = FS_W'(FILTER_BYTES);
      end else begin
         bytes_eff = cfg_filter_size;
      end
      if (cfg_hash_count > HC_W'(MAX_HASHES)) begin
         hc_eff = HC_W'(MAX_HASHES);
      end else begin
         hc_eff = cfg_hash_count;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RED_FIRST;
            end
         end
         ST_RED_FIRST: begin
            if (last_step) begin
               state_in = ST_RED_SECOND;
            end
         end
         ST_RED_SECOND: begin
            if (last_step) begin
               state_in = (n_ff == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = (cnt_next == n_ff) ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (mode_ff == MODE_ADD || !rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs toward the handshake, the modulo step and the store.
   always_comb begin
      req_ready       = 1'b0;
      mod_val         = '0;
      mod_m           = m_ff;
      mem_req         = '0;
      mem_req.addr    = idx_ff[IDX_W-1:3];
      result          = '0;
      result.member   = member_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !store_busy;
         end
         ST_RED_FIRST, ST_RED_SECOND: begin
            mod_val = {r_ff, shift_ff[SHIFT_W-1 -: 2]};
         end
         ST_READ: begin
            mem_req.rd_en = 1'b1;
         end
         ST_UPDATE: begin
            mod_val = ACC_W'(idx_ff) + ACC_W'(h2_ff);
            if (mode_ff == MODE_ADD) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = rd_data | (8'b1 << idx_ff[2:0]);
            end
         end
         ST_FINISH: begin
            result.valid = (mode_ff == MODE_CHECK) && !rsp_busy;
         end
         default: begin
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      mode_in   = mode_ff;
      shift_in  = shift_ff;
      step_in   = step_ff;
      r_in      = r_ff;
      h1_in     = h1_ff;
      h2_in     = h2_ff;
      idx_in    = idx_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      member_in = member_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = mode_type'(req_mode);
               shift_in  = {first_w3, first_w2, first_w1, first_w0,
                            second_w3, second_w2, second_w1, second_w0};
               step_in   = '0;
               r_in      = '0;
               m_in      = MOD_W'({bytes_eff, 3'b000});
               n_in      = CNT_W'(hc_eff);
               cnt_in    = '0;
               member_in = 1'b1;
            end
         end
         ST_RED_FIRST: begin
            shift_in = shift_ff << 2;
            step_in  = step_ff + STEP_W'(1);
            if (last_step) begin
               h1_in = mod_rem;
               r_in  = '0;
            end else begin
               r_in = mod_rem;
            end
         end
         ST_RED_SECOND: begin
            shift_in = shift_ff << 2;
            step_in  = step_ff + STEP_W'(1);
            r_in     = mod_rem;
            if (last_step) begin
               h2_in = mod_rem;
               idx_in = h1_ff;
            end
         end
         ST_UPDATE: begin
            idx_in = mod_rem;
            cnt_in = cnt_next;
            if (mode_ff == MODE_CHECK) begin
               member_in = member_ff & bit_set;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      shift_ff  <= shift_in;
      step_ff   <= step_in;
      r_ff      <= r_in;
      h1_ff     <= h1_in;
      h2_ff     <= h2_in;
      idx_ff    <= idx_in;
      m_ff      <= m_in;
      n_ff      <= n_in;
      cnt_ff    <= cnt_in;
      member_ff <= member_in;
   end

endmodule
